// ===== rtl/core/matrix_inverse_residual_norm_core_assert.svh =====
// Assertion macros used by the residual norm core checker.
`ifndef MATRIX_INVERSE_RESIDUAL_NORM_CORE_ASSERT_SVH
`define MATRIX_INVERSE_RESIDUAL_NORM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MIRN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MIRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mirn_pkg.sv =====
// Package with the constants and types of the residual norm core.
`timescale 1ns / 1ps
package mirn_pkg;

    localparam int MAX_ORDER = 64;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
    localparam int CFG_W     = 7;
    localparam int OP_W      = 2;
    localparam int FIELD_W   = 6;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int MAG_W     = ACC_W - 1;
    localparam int NORM_W    = 47;
    localparam int FRAC_W    = 24;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(MAX_ORDER);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic first_k;
        logic last_k;
        logic diag;
        logic first_i;
        logic last_i;
        logic last_j;
    } tag_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             clear;
        logic             issue;
        logic             load_out;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        tag_t             tag;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

// ===== rtl/core/mirn_datapath.sv =====
// Datapath: matrix memories and the multiply-accumulate and norm pipeline.
`timescale 1ns / 1ps
module mirn_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mirn_pkg::dp_cmd_t                    cmd,
    input  logic [mirn_pkg::FIELD_W-1:0]         row,
    input  logic [mirn_pkg::FIELD_W-1:0]         col,
    input  logic signed [mirn_pkg::VAL_W-1:0]    value,
    output mirn_pkg::dp_status_t                 status,
    output logic [mirn_pkg::NORM_W-1:0]          norm
);

    localparam logic signed [mirn_pkg::ACC_W-1:0] ONE_Q24 =
        mirn_pkg::ACC_W'(1) << mirn_pkg::FRAC_W;

    logic signed [mirn_pkg::VAL_W-1:0] mem_a [mirn_pkg::DEPTH];
    logic signed [mirn_pkg::VAL_W-1:0] mem_b [mirn_pkg::DEPTH];

    logic [mirn_pkg::ADDR_W-1:0] wr_addr;
    logic [mirn_pkg::ADDR_W-1:0] rd_addr_a;
    logic [mirn_pkg::ADDR_W-1:0] rd_addr_b;

    logic signed [mirn_pkg::VAL_W-1:0]  a_rd_reg;
    logic signed [mirn_pkg::VAL_W-1:0]  b_rd_reg;
    logic                               s1_vld_reg;
    mirn_pkg::tag_t                     s1_tag_reg;

    logic signed [mirn_pkg::PROD_W-1:0] prod_reg;
    logic                               s2_vld_reg;
    mirn_pkg::tag_t                     s2_tag_reg;

    logic signed [mirn_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mirn_pkg::ACC_W-1:0]  acc_base;
    logic signed [mirn_pkg::ACC_W-1:0]  acc_next;
    logic                               s3_vld_reg;
    mirn_pkg::tag_t                     s3_tag_reg;

    logic [mirn_pkg::ACC_W-1:0]         acc_abs;
    logic [mirn_pkg::MAG_W-1:0]         mag_reg;
    logic                               s4_vld_reg;
    mirn_pkg::tag_t                     s4_tag_reg;

    logic [mirn_pkg::NORM_W-1:0]        col_reg;
    logic [mirn_pkg::NORM_W-1:0]        col_next;
    logic                               s5_vld_reg;
    logic                               s5_last_j_reg;

    logic [mirn_pkg::NORM_W-1:0]        best_reg;
    logic [mirn_pkg::NORM_W-1:0]        norm_reg;
    logic                               done_reg;

    assign wr_addr   = {mirn_pkg::IDX_W'(row), mirn_pkg::IDX_W'(col)};
    assign rd_addr_a = {cmd.i, cmd.k};
    assign rd_addr_b = {cmd.k, cmd.j};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
        begin
            mem_a[wr_addr] <= value;
        end
        if (cmd.issue)
        begin
            a_rd_reg <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
        begin
            mem_b[wr_addr] <= value;
        end
        if (cmd.issue)
        begin
            b_rd_reg <= mem_b[rd_addr_b];
        end
    end

    // A diagonal element starts its sum at minus one so the identity costs no extra adder.
    always_comb
    begin
        if (s2_tag_reg.first_k)
        begin
            acc_base = s2_tag_reg.diag ? -ONE_Q24 : '0;
        end
        else
        begin
            acc_base = acc_reg;
        end
        acc_next = acc_base + mirn_pkg::ACC_W'(prod_reg);
        acc_abs  = acc_reg[mirn_pkg::ACC_W-1] ? mirn_pkg::ACC_W'(-acc_reg)
                                                : mirn_pkg::ACC_W'(acc_reg);
        col_next = (s4_tag_reg.first_i ? '0 : col_reg) + mirn_pkg::NORM_W'(mag_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= cmd.tag;
        prod_reg   <= a_rd_reg * b_rd_reg;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        s4_tag_reg <= s3_tag_reg;
        if (s2_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s3_vld_reg)
        begin
            mag_reg <= acc_abs[mirn_pkg::MAG_W-1:0];
        end
        if (s4_vld_reg)
        begin
            col_reg <= col_next;
        end
        s5_last_j_reg <= s4_tag_reg.last_j;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            best_reg   <= '0;
            norm_reg   <= '0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg && s2_tag_reg.last_k;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg && s4_tag_reg.last_i;
            done_reg   <= s5_vld_reg && s5_last_j_reg;
            if (cmd.clear)
            begin
                best_reg <= '0;
            end
            else if (s5_vld_reg && (col_reg > best_reg))
            begin
                best_reg <= col_reg;
            end
            if (cmd.load_out)
            begin
                norm_reg <= best_reg;
            end
        end
    end

    assign status.done = done_reg;
    assign norm        = norm_reg;

endmodule

// ===== rtl/core/mirn_controller.sv =====
// Controller: request handshake, size register and the i, j, k sequencer.
`timescale 1ns / 1ps
module mirn_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mirn_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mirn_pkg::OP_W-1:0]      op,
    input  logic [mirn_pkg::FIELD_W-1:0]   row,
    input  logic [mirn_pkg::FIELD_W-1:0]   col,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mirn_pkg::dp_cmd_t              cmd,
    input  mirn_pkg::dp_status_t           status
);

    mirn_pkg::state_t state_reg;
    mirn_pkg::state_t state_next;

    logic [mirn_pkg::CFG_W-1:0] size_reg;
    logic [mirn_pkg::IDX_W-1:0] lim_reg;
    logic [mirn_pkg::IDX_W-1:0] lim_next;
    logic [mirn_pkg::IDX_W-1:0] i_reg;
    logic [mirn_pkg::IDX_W-1:0] i_next;
    logic [mirn_pkg::IDX_W-1:0] j_reg;
    logic [mirn_pkg::IDX_W-1:0] j_next;
    logic [mirn_pkg::IDX_W-1:0] k_reg;
    logic [mirn_pkg::IDX_W-1:0] k_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic in_fire;
    logic in_range;
    logic start;
    logic last_k;
    logic last_i;
    logic last_j;
    logic out_free;
    logic load_out;

    assign in_fire  = in_valid && in_ready;
    assign in_range = (int'(row) < mirn_pkg::MAX_ORDER) && (int'(col) < mirn_pkg::MAX_ORDER);
    assign start    = in_fire && (op == mirn_pkg::OP_COMPUTE);
    assign last_k   = (k_reg == lim_reg);
    assign last_i   = (i_reg == lim_reg);
    assign last_j   = (j_reg == lim_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == mirn_pkg::ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mirn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mirn_pkg::ST_RUN;
                end
            end
            mirn_pkg::ST_RUN:
            begin
                if (last_k && last_i && last_j)
                begin
                    state_next = mirn_pkg::ST_DRAIN;
                end
            end
            mirn_pkg::ST_DRAIN:
            begin
                if (status.done)
                begin
                    state_next = mirn_pkg::ST_DONE;
                end
            end
            mirn_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mirn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mirn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == mirn_pkg::ST_IDLE);
        out_valid     = out_valid_reg;
        cmd.wr_a      = in_fire && (op == mirn_pkg::OP_LOAD_A) && in_range;
        cmd.wr_b      = in_fire && (op == mirn_pkg::OP_LOAD_B) && in_range;
        cmd.clear     = start;
        cmd.issue     = (state_reg == mirn_pkg::ST_RUN);
        cmd.load_out  = load_out;
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
        cmd.tag.first_k = (k_reg == '0);
        cmd.tag.last_k  = last_k;
        cmd.tag.diag    = (i_reg == j_reg);
        cmd.tag.first_i = (i_reg == '0);
        cmd.tag.last_i  = last_i;
        cmd.tag.last_j  = last_j;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Order zero runs as order one; an order above the memory size runs as the full size.
    always_comb
    begin
        if (size_reg == '0)
        begin
            lim_next = '0;
        end
        else if (int'(size_reg) > mirn_pkg::MAX_ORDER)
        begin
            lim_next = mirn_pkg::IDX_W'(mirn_pkg::MAX_ORDER - 1);
        end
        else
        begin
            lim_next = mirn_pkg::IDX_W'(size_reg - 1'b1);
        end
    end

    // Column j outermost, then row i, then the inner product index k.
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (start)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end
        else if (state_reg == mirn_pkg::ST_RUN)
        begin
            if (!last_k)
            begin
                k_next = k_reg + 1'b1;
            end
            else
            begin
                k_next = '0;
                if (!last_i)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    i_next = '0;
                    j_next = j_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mirn_pkg::ST_IDLE;
            size_reg      <= mirn_pkg::SIZE_RESET;
            lim_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (start)
            begin
                lim_reg <= lim_next;
            end
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/matrix_inverse_residual_norm_core.sv =====
// Top level of the residual norm core: 1-norm of A*B - I over two loaded matrices.
`timescale 1ns / 1ps
// Load requests (op 0 for A, op 1 for B) are taken one per cycle while the core
// is idle and write one signed Q4.12 element into a 64 x 64 on-chip memory per
// matrix; elements must be written before a compute reads them. A compute request
// (op 2) runs n*n*n multiply-accumulates through the single multiplier, one per
// cycle, with n the clamped matrix_size register; its norm reaches the output
// register once the last column sum has left the pipeline, and requests are
// refused until then. The output register holds the norm until it is taken while
// loads and a further compute go on; the result of that compute waits inside the
// core, with requests refused, until the register is free. The result is unsigned
// Q.24. Write matrix_size only while idle.
module matrix_inverse_residual_norm_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mirn_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [mirn_pkg::OP_W-1:0]            op,
    input  logic [mirn_pkg::FIELD_W-1:0]         row,
    input  logic [mirn_pkg::FIELD_W-1:0]         col,
    input  logic signed [mirn_pkg::VAL_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mirn_pkg::NORM_W-1:0]          norm
);

    mirn_pkg::dp_cmd_t    cmd;
    mirn_pkg::dp_status_t status;

    mirn_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .row       (row),
        .col       (col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    mirn_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .row    (row),
        .col    (col),
        .value  (value),
        .status (status),
        .norm   (norm)
    );

endmodule

// ===== rtl/core/mirn_checker.sv =====
// Port-level checker for the residual norm core and its bind statement.
`timescale 1ns / 1ps
`include "matrix_inverse_residual_norm_core_assert.svh"
module mirn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [mirn_pkg::OP_W-1:0]     op,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mirn_pkg::NORM_W-1:0]   norm
);

`MIRN_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && (op == mirn_pkg::OP_COMPUTE), !in_ready, "Compute did not block the input.")
`MIRN_ASSERT_NEXT(a_load_no_stall, in_valid && in_ready && (op != mirn_pkg::OP_COMPUTE), in_ready, "Load request stalled the input.")
`MIRN_ASSERT_NEXT(a_no_stray_result, in_ready && !out_valid, !out_valid, "Result appeared without a finished compute.")
`MIRN_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(norm), "Stalled result changed.")

endmodule

bind matrix_inverse_residual_norm_core mirn_checker u_mirn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .norm      (norm)
);
